// ===== sv/bole_pkg.sv =====
`default_nettype none
package bole_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned ITEM_W   = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_PREPEND = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_REM_IDX = 3'd3,
        CMD_REM_VAL = 3'd4,
        CMD_CLEAR   = 3'd5,
        CMD_DUMP    = 3'd6,
        CMD_NOP     = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_DUMP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic apply;
        logic dump_step;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic dump_go;
        logic dump_end;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/bole_ctrl.sv =====
`default_nettype none
module bole_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  bole_pkg::t_dp_stat   i_stat,
    output bole_pkg::t_ctrl_cmd  o_cmd
);
    import bole_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_stat.dump_go) begin
                    n_state = S_DUMP;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free && i_stat.dump_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load_in   = 1'b0;
        o_cmd.apply     = 1'b0;
        o_cmd.dump_step = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_APPLY: begin
                // a non-empty dump hands over to the element walk
                o_cmd.apply = i_stat.out_free && !i_stat.dump_go;
            end
            S_DUMP: begin
                o_cmd.dump_step = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/bole_dp.sv =====
`default_nettype none
module bole_dp #(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  bole_pkg::t_ctrl_cmd               i_cmd,
    output bole_pkg::t_dp_stat                o_stat,
    input  wire [bole_pkg::IN_W-1:0]          i_in_data,
    input  wire                               i_out_ready,
    output logic                              o_out_valid,
    output logic [bole_pkg::OUT_W-1:0]        o_out_data,
    output logic                              o_out_last
);
    import bole_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned XW = CW + 6;

    logic [VALUE_WIDTH-1:0] r_cell [CAPACITY];
    logic [VALUE_WIDTH-1:0] n_cell [CAPACITY];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [CAPACITY-1:0]    r_match;
    logic [CAPACITY-1:0]    n_match;
    logic [PW-1:0]          r_pos;
    t_cmd                   r_op;
    logic [IDX_W-1:0]       r_idx;
    logic [VALUE_WIDTH-1:0] r_val;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [COUNT_W-1:0]     r_out_count;
    logic [ITEM_W-1:0]      r_out_value;
    logic [POS_W-1:0]       r_out_pos;
    logic                   r_out_last;

    logic [ITEM_W-1:0]      in_item;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [ITEM_W+VALUE_WIDTH-1:0] in_ext;
    logic [ITEM_W+VALUE_WIDTH-1:0] head_ext;
    logic [COUNT_W+CW-1:0]  count_ext;
    logic [COUNT_W+CW-1:0]  n_count_ext;
    logic [POS_W+PW-1:0]    pos_ext;
    logic [CAPACITY-1:0]    low_bit;
    logic [CAPACITY-1:0]    val_mask;
    logic                   full;
    logic                   empty;
    logic                   out_free;
    logic                   dump_end;
    t_status                apply_st;
    logic                   do_ins;
    logic [XW-1:0]          ins_at;
    logic                   do_rem;
    logic [CAPACITY-1:0]    rem_mask;

    assign in_item  = i_in_data[IN_W-1:CMD_W+IDX_W];
    assign in_ext   = {{VALUE_WIDTH{in_item[ITEM_W-1]}}, in_item};
    assign in_val   = in_ext[VALUE_WIDTH-1:0];
    assign head_ext = {{ITEM_W{r_cell[0][VALUE_WIDTH-1]}}, r_cell[0]};
    assign count_ext = {{COUNT_W{1'b0}}, r_count};
    assign n_count_ext = {{COUNT_W{1'b0}}, n_count};
    assign pos_ext   = {{POS_W{1'b0}}, r_pos};

    assign full     = (XW'(r_count) >= XW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign out_free = !r_out_valid || i_out_ready;
    assign dump_end = (XW'(r_pos) + XW'(1)) == XW'(r_count);

    // first match and every cell above it close up
    assign low_bit  = r_match & (~r_match + CAPACITY'(1));
    assign val_mask = ~(low_bit - CAPACITY'(1));

    assign o_stat.out_free = out_free;
    assign o_stat.dump_go  = (r_op == CMD_DUMP) && !empty;
    assign o_stat.dump_end = dump_end;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_match[i] = (r_cell[i] == in_val) && (XW'(i) < XW'(r_count));
        end
    end

    always_comb begin
        apply_st = ST_OK;
        do_ins   = 1'b0;
        ins_at   = '0;
        do_rem   = 1'b0;
        rem_mask = '0;
        n_count  = r_count;
        case (r_op)
            CMD_APPEND, CMD_PREPEND: begin
                if (full) begin
                    apply_st = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    ins_at = (r_op == CMD_APPEND) ? XW'(r_count) : '0;
                end
            end
            CMD_INSERT: begin
                if (XW'(r_idx) > XW'(r_count)) begin
                    apply_st = ST_RANGE;
                end else if (full) begin
                    apply_st = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    ins_at = XW'(r_idx);
                end
            end
            CMD_REM_IDX: begin
                if (empty) begin
                    apply_st = ST_EMPTY;
                end else if (XW'(r_idx) >= XW'(r_count)) begin
                    apply_st = ST_RANGE;
                end else begin
                    do_rem = 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        rem_mask[i] = (XW'(i) >= XW'(r_idx));
                    end
                end
            end
            CMD_REM_VAL: begin
                if (empty) begin
                    apply_st = ST_EMPTY;
                end else if (r_match == '0) begin
                    apply_st = ST_NOT_FOUND;
                end else begin
                    do_rem   = 1'b1;
                    rem_mask = val_mask;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_DUMP: begin
                // only reached here on an empty list
                apply_st = ST_EMPTY;
            end
            default: begin
                apply_st = ST_OK;
            end
        endcase
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end
        if (do_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.apply && do_ins) begin
                if (XW'(i) == ins_at) begin
                    n_cell[i] = r_val;
                end else if (XW'(i) > ins_at && i > 0) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.apply && do_rem) begin
                if (rem_mask[i] && i + 1 < CAPACITY) begin
                    n_cell[i] = r_cell[(i + 1 < CAPACITY) ? i + 1 : i];
                end
            end else if (i_cmd.dump_step) begin
                // rotate within the used part so the list is whole after the walk
                if (XW'(i) + XW'(1) == XW'(r_count)) begin
                    n_cell[i] = r_cell[0];
                end else if (i + 1 < CAPACITY) begin
                    n_cell[i] = r_cell[(i + 1 < CAPACITY) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (i_cmd.load_in) begin
            r_op    <= t_cmd'(i_in_data[CMD_W-1:0]);
            r_idx   <= i_in_data[CMD_W+IDX_W-1:CMD_W];
            r_val   <= in_val;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.apply) begin
                r_count <= n_count;
            end
            if (i_cmd.load_in) begin
                r_pos <= '0;
            end else if (i_cmd.dump_step) begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply || i_cmd.dump_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out_status <= apply_st;
            r_out_count  <= n_count_ext[COUNT_W-1:0];
            r_out_value  <= '0;
            r_out_pos    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.dump_step) begin
            r_out_status <= ST_OK;
            r_out_count  <= count_ext[COUNT_W-1:0];
            r_out_value  <= head_ext[ITEM_W-1:0];
            r_out_pos    <= pos_ext[POS_W-1:0];
            r_out_last   <= dump_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_W - STATUS_W - COUNT_W - ITEM_W - POS_W){1'b0}},
                          r_out_pos, r_out_value, r_out_count, r_out_status};
    assign o_out_last  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("entry count above capacity");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_op == CMD_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_op == CMD_APPEND && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the list");

    a_dump_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dump_step |=> (r_count == $past(r_count)))
        else $error("dump changed the entry count");

endmodule
`default_nettype wire

// ===== sv/bounded_ordered_list_engine_unit.sv =====
`default_nettype none
// Ordered list of up to CAPACITY signed values held in a row of cells with a
// count. Each command transfer on the slave side gives one result transfer,
// except dump, which gives one per element (tlast on the final one) or a
// single "list empty" result. An edit passes through the input transfer,
// where every cell is compared with the value in parallel, and then the
// apply state, where the cells shift up or down at once when the output
// register is free. In a dump the row rotates through cell 0, which feeds
// the output register. The output register lets the next command be taken
// while a result still waits on the master side.
module bounded_ordered_list_engine_unit #(
    parameter int unsigned CAPACITY    = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // cmd[2:0], position_index[7:3], item_value[39:8]
    input  wire [bole_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // status[2:0], element_count[7:3], dump_value[39:8], dump_position[43:40]
    output logic [bole_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast
);
    import bole_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    bole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (ctrl_cmd)
    );

    bole_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire
